// ===== design/sre_pkg.sv =====
// ----------------------------------------------------------------------------
// sre_pkg
// Shared types, widths, trig table and angle constants of the sensor ring
// direction estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package sre_pkg;

    // field widths
    localparam int BITS_W   = 32;
    localparam int CENTER_W = 5;
    localparam int RADIUS_W = 4;
    localparam int ANGLE_W  = 15;
    localparam int COUNT_W  = 5;

    // configuration port
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_WINDOW_RADIUS = 2'd0;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd7;

    // one lane per window position: at most 2*15+1 positions
    localparam int LANE_COUNT = 31;
    localparam int GROUP_COUNT = 8;
    localparam int GROUP_SIZE = 4;

    // arithmetic widths
    localparam int TRIG_W = 16;     // q1.14 cos/sin, +-16384
    localparam int PART_W = 18;     // sum of four lanes
    localparam int SUM_W  = 20;     // sum of all lanes
    localparam int GCNT_W = 3;      // active count of four lanes
    localparam int CORD_W = 34;     // cordic x/y datapath
    localparam int Z_W    = 24;     // angle accumulator, 1/16384 degree
    localparam int ITER   = 16;
    localparam int PRE_SHIFT = 10;

    localparam logic signed [Z_W-1:0] HALF_TURN = 24'sd2949120;
    localparam logic signed [Z_W-1:0] FULL_TURN = 24'sd5898240;
    localparam logic signed [Z_W-1:0] ROUND_HALF = 24'sd128;
    localparam logic [15:0] OUT_WRAP = 16'd23040;

    // atan(2^-i) in 1/16384 degree
    localparam logic signed [Z_W-1:0] ATAN_STEP [ITER] = '{
        24'sd737280, 24'sd435242, 24'sd229970, 24'sd116736,
        24'sd58595,  24'sd29326,  24'sd14667,  24'sd7334,
        24'sd3667,   24'sd1833,   24'sd917,    24'sd458,
        24'sd229,    24'sd115,    24'sd57,     24'sd29
    };

    typedef struct packed {
        logic                     active;
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
    } lane_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic [COUNT_W-1:0]      count;
    } sum_t;

    typedef struct packed {
        logic               angle_valid;
        logic [ANGLE_W-1:0] direction_angle;
        logic [COUNT_W-1:0] active_count;
    } result_t;

    // first quadrant cosine in steps of 11.25 degrees
    function automatic logic signed [TRIG_W-1:0] quarter_cos(input logic [3:0] idx);
        logic signed [TRIG_W-1:0] c;
        case (idx)
            4'd0:    c = 16'sd16384;
            4'd1:    c = 16'sd16069;
            4'd2:    c = 16'sd15137;
            4'd3:    c = 16'sd13623;
            4'd4:    c = 16'sd11585;
            4'd5:    c = 16'sd9102;
            4'd6:    c = 16'sd6270;
            4'd7:    c = 16'sd3196;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

    // cosine of sensor k at k*11.25 degrees
    function automatic logic signed [TRIG_W-1:0] ring_cos(input logic [4:0] k);
        logic [3:0] r;
        logic [3:0] rr;
        logic signed [TRIG_W-1:0] c;
        r  = {1'b0, k[2:0]};
        rr = 4'd8 - r;
        case (k[4:3])
            2'd0:    c = quarter_cos(r);
            2'd1:    c = -quarter_cos(rr);
            2'd2:    c = -quarter_cos(r);
            default: c = quarter_cos(rr);
        endcase
        return c;
    endfunction

    // sine is the cosine a quarter turn back
    function automatic logic signed [TRIG_W-1:0] ring_sin(input logic [4:0] k);
        return ring_cos(k + 5'd24);
    endfunction

endpackage

`default_nettype wire

// ===== design/sre_if.sv =====
// ----------------------------------------------------------------------------
// sre_if
// Valid/ready channels of the estimator: snapshot words in, result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sre_in_if;
    import sre_pkg::*;

    logic                valid;
    logic                ready;
    logic [BITS_W-1:0]   sensor_bits;
    logic [CENTER_W-1:0] window_center;

    modport source (output valid, output sensor_bits, output window_center, input ready);
    modport sink   (input valid, input sensor_bits, input window_center, output ready);
endinterface

interface sre_out_if;
    import sre_pkg::*;

    logic               valid;
    logic               ready;
    logic               angle_valid;
    logic [ANGLE_W-1:0] direction_angle;
    logic [COUNT_W-1:0] active_count;

    modport source (output valid, output angle_valid, output direction_angle,
                    output active_count, input ready);
    modport sink   (input valid, input angle_valid, input direction_angle,
                    input active_count, output ready);
endinterface

`default_nettype wire

// ===== design/sre_lane.sv =====
// ----------------------------------------------------------------------------
// sre_lane
// One window position: ring index, active test and cos/sin contribution,
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sre_lane #(
    parameter int SENSOR_COUNT = 32,
    parameter int LANE_IDX     = 0
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [sre_pkg::BITS_W-1:0]      sensor_bits,
    input  logic [sre_pkg::CENTER_W-1:0]    window_center,
    input  logic [sre_pkg::RADIUS_W-1:0]    radius,
    output sre_pkg::lane_t                  lane
);
    import sre_pkg::*;

    localparam int POS_W = 10;
    localparam logic [POS_W-1:0] OFFSET = POS_W'(LANE_IDX + 2 * SENSOR_COUNT);
    localparam logic [POS_W-1:0] MOD8 = POS_W'(8 * SENSOR_COUNT);
    localparam logic [POS_W-1:0] MOD4 = POS_W'(4 * SENSOR_COUNT);
    localparam logic [POS_W-1:0] MOD2 = POS_W'(2 * SENSOR_COUNT);
    localparam logic [POS_W-1:0] MOD1 = POS_W'(SENSOR_COUNT);
    localparam logic [4:0] LANE_POS = 5'(LANE_IDX);

    logic [POS_W-1:0] v;
    logic [4:0]       pos;
    logic             in_window;
    lane_t            lane_next;
    lane_t            lane_reg;

    // ring position reduced by conditional subtraction of multiples
    always_comb
    begin
        v = {6'd0, window_center[3:0]} + {5'd0, window_center[4], 4'd0} + OFFSET
            - POS_W'(radius);
        if (v >= MOD8)
        begin
            v = v - MOD8;
        end
        if (v >= MOD4)
        begin
            v = v - MOD4;
        end
        if (v >= MOD2)
        begin
            v = v - MOD2;
        end
        if (v >= MOD1)
        begin
            v = v - MOD1;
        end
    end

    assign pos       = v[4:0];
    assign in_window = ({radius, 1'b0} >= LANE_POS);

    // contribution of this position
    always_comb
    begin
        lane_next.active = in_window && !sensor_bits[pos];
        lane_next.x      = lane_next.active ? ring_cos(pos) : '0;
        lane_next.y      = lane_next.active ? ring_sin(pos) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane = lane_reg;

endmodule

`default_nettype wire

// ===== design/sre_merge.sv =====
// ----------------------------------------------------------------------------
// sre_merge
// Two-stage registered adder tree over the lane contributions and the
// active flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sre_merge (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  sre_pkg::lane_t lanes [sre_pkg::LANE_COUNT],
    output logic           out_valid,
    output sre_pkg::sum_t  sum
);
    import sre_pkg::*;

    lane_t                    padded [GROUP_COUNT * GROUP_SIZE];
    logic signed [PART_W-1:0] px_next [GROUP_COUNT];
    logic signed [PART_W-1:0] py_next [GROUP_COUNT];
    logic [GCNT_W-1:0]        pc_next [GROUP_COUNT];
    logic signed [PART_W-1:0] px_reg  [GROUP_COUNT];
    logic signed [PART_W-1:0] py_reg  [GROUP_COUNT];
    logic [GCNT_W-1:0]        pc_reg  [GROUP_COUNT];
    logic                     part_v_reg;
    sum_t                     sum_next;
    sum_t                     sum_reg;
    logic                     sum_v_reg;

    // pad the lane row to a full group count
    always_comb
    begin
        for (int i = 0; i < GROUP_COUNT * GROUP_SIZE; i++)
        begin
            padded[i] = '0;
        end
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            padded[i] = lanes[i];
        end
    end

    // first level: groups of four lanes
    always_comb
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            px_next[g] = '0;
            py_next[g] = '0;
            pc_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                px_next[g] = px_next[g] + PART_W'(padded[g * GROUP_SIZE + k].x);
                py_next[g] = py_next[g] + PART_W'(padded[g * GROUP_SIZE + k].y);
                pc_next[g] = pc_next[g] + GCNT_W'(padded[g * GROUP_SIZE + k].active);
            end
        end
    end

    // second level: the eight group sums
    always_comb
    begin
        sum_next = '0;
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            sum_next.x     = sum_next.x + SUM_W'(px_reg[g]);
            sum_next.y     = sum_next.y + SUM_W'(py_reg[g]);
            sum_next.count = sum_next.count + COUNT_W'(pc_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            pc_reg  <= pc_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_v_reg <= 1'b0;
            sum_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            part_v_reg <= in_valid;
            sum_v_reg  <= part_v_reg;
        end
    end

    assign out_valid = sum_v_reg;
    assign sum       = sum_reg;

endmodule

`default_nettype wire

// ===== design/sre_cordic.sv =====
// ----------------------------------------------------------------------------
// sre_cordic
// Pipelined cordic vectoring: half plane fold, sixteen iteration stages and
// a final stage that wraps and rounds the angle to 1/64 degree.
// ----------------------------------------------------------------------------
`default_nettype none

module sre_cordic (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  sre_pkg::sum_t    sum,
    output logic             out_valid,
    output sre_pkg::result_t result
);
    import sre_pkg::*;

    typedef struct packed {
        logic               has_active;
        logic               zero_vec;
        logic [COUNT_W-1:0] count;
    } meta_t;

    logic signed [CORD_W-1:0] x_reg [ITER + 1];
    logic signed [CORD_W-1:0] y_reg [ITER + 1];
    logic signed [Z_W-1:0]    z_reg [ITER + 1];
    meta_t                    m_reg [ITER + 1];
    logic [ITER:0]            v_reg;
    logic signed [CORD_W-1:0] x_next [ITER + 1];
    logic signed [CORD_W-1:0] y_next [ITER + 1];
    logic signed [Z_W-1:0]    z_next [ITER + 1];
    meta_t                    m_next;
    logic signed [CORD_W-1:0] xw;
    logic signed [CORD_W-1:0] yw;
    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;
    logic signed [Z_W-1:0]    z_wrap;
    logic signed [Z_W-1:0]    z_round;
    logic [15:0]              ang_raw;
    logic [15:0]              ang_fix;
    result_t                  res_next;
    result_t                  res_reg;
    logic                     res_v_reg;

    // fold the left half plane onto the right
    assign xw = CORD_W'(sum.x) <<< PRE_SHIFT;
    assign yw = CORD_W'(sum.y) <<< PRE_SHIFT;

    always_comb
    begin
        if (sum.x < 0)
        begin
            x_next[0] = -xw;
            y_next[0] = -yw;
            z_next[0] = HALF_TURN;
        end
        else
        begin
            x_next[0] = xw;
            y_next[0] = yw;
            z_next[0] = '0;
        end
        m_next.has_active = (sum.count != '0);
        m_next.zero_vec   = (sum.x == '0) && (sum.y == '0);
        m_next.count      = sum.count;

        // one micro-rotation per stage
        xs = '0;
        ys = '0;
        for (int i = 0; i < ITER; i++)
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (!y_reg[i][CORD_W-1])
            begin
                x_next[i + 1] = x_reg[i] + ys;
                y_next[i + 1] = y_reg[i] - xs;
                z_next[i + 1] = z_reg[i] + ATAN_STEP[i];
            end
            else
            begin
                x_next[i + 1] = x_reg[i] - ys;
                y_next[i + 1] = y_reg[i] + xs;
                z_next[i + 1] = z_reg[i] - ATAN_STEP[i];
            end
        end
    end

    // wrap into one turn and round to 1/64 degree
    assign z_wrap  = z_reg[ITER][Z_W-1] ? (z_reg[ITER] + FULL_TURN) : z_reg[ITER];
    assign z_round = z_wrap + ROUND_HALF;
    assign ang_raw = z_round[Z_W-1:8];
    assign ang_fix = (ang_raw >= OUT_WRAP) ? (ang_raw - OUT_WRAP) : ang_raw;

    always_comb
    begin
        res_next.angle_valid     = m_reg[ITER].has_active;
        res_next.direction_angle = (m_reg[ITER].has_active && !m_reg[ITER].zero_vec)
                                   ? ang_fix[ANGLE_W-1:0] : '0;
        res_next.active_count    = m_reg[ITER].count;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x_next[0];
            y_reg[0] <= y_next[0];
            z_reg[0] <= z_next[0];
            m_reg[0] <= m_next;
            for (int i = 1; i <= ITER; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
                m_reg[i] <= m_reg[i - 1];
            end
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            res_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[ITER-1:0], in_valid};
            res_v_reg <= v_reg[ITER];
        end
    end

    assign out_valid = res_v_reg;
    assign result    = res_reg;

endmodule

`default_nettype wire

// ===== design/sensor_ring_direction_estimator.sv =====
// ----------------------------------------------------------------------------
// sensor_ring_direction_estimator
// Direction of the active sensors of a ring snapshot inside a window around
// a centre index, as the angle of their summed unit vectors.
// ----------------------------------------------------------------------------
//  channel      dir  handshake      word
//  sample_in    in   valid/ready    sensor_bits, window_center
//  result_out   out  valid/ready    angle_valid, direction_angle, active_count
//  apb          in   psel/penable   window_radius at byte address 0
//
//  One word is accepted every cycle while the skid register is empty; each
//  result is offered through 21 register stages: one lane stage, two adder
//  tree stages, the half plane fold, sixteen cordic stages and the rounding
//  stage.
//  When result_out stalls, the finished word moves into a skid register and
//  the pipeline freezes in the cycle after, so one more word is still taken.
//  Reset clears all valid flags and sets window_radius to 7.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_ring_direction_estimator #(
    parameter int SENSOR_COUNT = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sre_pkg::PADDR_W-1:0]   paddr,
    input  logic [sre_pkg::PDATA_W-1:0]   pwdata,
    output logic [sre_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    sre_in_if.sink                        sample_in,
    sre_out_if.source                     result_out
);
    import sre_pkg::*;

    logic [RADIUS_W-1:0] radius_reg;
    logic                en;
    logic                lane_v_reg;
    lane_t               lanes [LANE_COUNT];
    logic                sum_v;
    sum_t                sum;
    logic                fin_v;
    result_t             fin;
    result_t             skid_reg;
    logic                skid_v_reg;
    logic                skid_v_next;
    result_t             shown;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_RADIUS))
        begin
            radius_reg <= pwdata[RADIUS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WINDOW_RADIUS) ? PDATA_W'(radius_reg) : '0;

    // pipeline advances unless a word sits in the skid register
    assign en              = !skid_v_reg;
    assign sample_in.ready = en;

    // one lane per window position
    for (genvar i = 0; i < LANE_COUNT; i++)
    begin : g_lane
        sre_lane #(
            .SENSOR_COUNT (SENSOR_COUNT),
            .LANE_IDX     (i)
        ) u_lane (
            .clk           (clk),
            .en            (en),
            .sensor_bits   (sample_in.sensor_bits),
            .window_center (sample_in.window_center),
            .radius        (radius_reg),
            .lane          (lanes[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_v_reg <= 1'b0;
        end
        else if (en)
        begin
            lane_v_reg <= sample_in.valid;
        end
    end

    // merge the lanes
    sre_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (lane_v_reg),
        .lanes     (lanes),
        .out_valid (sum_v),
        .sum       (sum)
    );

    // angle of the summed vector
    sre_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sum_v),
        .sum       (sum),
        .out_valid (fin_v),
        .result    (fin)
    );

    // output skid register
    always_comb
    begin
        if (skid_v_reg)
        begin
            skid_v_next = !result_out.ready;
        end
        else
        begin
            skid_v_next = fin_v && !result_out.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
        end
        else
        begin
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg && fin_v && !result_out.ready)
        begin
            skid_reg <= fin;
        end
    end

    assign shown                      = skid_v_reg ? skid_reg : fin;
    assign result_out.valid           = skid_v_reg || fin_v;
    assign result_out.angle_valid     = shown.angle_valid;
    assign result_out.direction_angle = shown.direction_angle;
    assign result_out.active_count    = shown.active_count;

endmodule

`default_nettype wire

// ===== sim/sensor_ring_direction_estimator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_ring_direction_estimator_test
// Drives ring snapshots through the estimator under random input gaps,
// output stalls and one long output hold-off. Every result word is checked
// field by field against a local model of the window sum and cordic angle,
// over several window radius settings written through the apb port.
// ----------------------------------------------------------------------------

module sensor_ring_direction_estimator_test;
    import sre_pkg::*;

    localparam int SENSOR_COUNT = 32;
    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PIPE_DEPTH = 30;
    localparam int CHOKE_CYCLES = 250;
    localparam int PHASE_WORDS = 150;
    localparam int PHASES = 8;
    localparam int MAX_REPORTS = 40;
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = 2'd1;

    // q1.14 cosine of the first quadrant in 11.25 degree steps
    localparam int COS_Q14 [9] = '{16384, 16069, 15137, 13623, 11585, 9102, 6270, 3196, 0};
    // atan(2^-i) in 1/16384 degree
    localparam longint ATAN_Q14 [16] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29
    };
    localparam longint HALF_CIRCLE = 180 * 16384;
    localparam longint FULL_CIRCLE = 360 * 16384;
    localparam longint ANGLE_WRAP = 23040;

    typedef struct {
        logic [BITS_W-1:0]   bits;
        logic [CENTER_W-1:0] center;
    } snapshot_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    sre_in_if  sample_in ();
    sre_out_if result_out ();

    snapshot_t snapshot_queue [$];
    result_t   direction_queue [$];

    logic [RADIUS_W-1:0] scan_radius = RADIUS_RESET;
    logic in_idle_on = 1'b0;
    logic out_idle_on = 1'b0;
    logic choke_arm = 1'b0;
    logic choke_used = 1'b0;
    int choke_left = 0;
    int gap_left = 0;
    int stall_left = 0;
    logic out_ready_q = 1'b0;
    int cycle_count = 0;
    int words_accepted = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int empty_windows = 0;
    int zero_angles = 0;
    int radius_settings = 1;

    sensor_ring_direction_estimator #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sample_in  (sample_in),
        .result_out (result_out)
    );

    // output ready: per-word stall gated by the long hold-off
    assign result_out.ready = out_ready_q && (choke_left == 0);

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // cosine of ring position k at k*11.25 degrees
    function automatic int sensor_cos(int k);
        int q;
        int r;
        int c;
        q = (k & 31) >> 3;
        r = k & 7;
        case (q)
            0:       c = COS_Q14[r];
            1:       c = -COS_Q14[8 - r];
            2:       c = -COS_Q14[r];
            default: c = COS_Q14[8 - r];
        endcase
        return c;
    endfunction

    // window vector sum, then cordic vectoring to an angle in 1/64 degree
    function automatic result_t estimate_direction(logic [BITS_W-1:0] bits,
                                                   logic [CENTER_W-1:0] center,
                                                   logic [RADIUS_W-1:0] radius);
        result_t res;
        longint sx;
        longint sy;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint angle;
        int pos;
        int hits;
        int j;
        res = '0;
        sx = 0;
        sy = 0;
        hits = 0;
        for (j = 0; j <= 2 * int'(radius); j++)
        begin
            pos = (int'(center) - int'(radius) + j + 16 * SENSOR_COUNT) % SENSOR_COUNT;
            if (!bits[pos])
            begin
                sx += sensor_cos(pos);
                sy += sensor_cos(pos + 24);
                hits++;
            end
        end
        if (hits == 0)
            return res;
        res.angle_valid = 1'b1;
        res.active_count = COUNT_W'(hits);
        // sensors that cancel exactly give angle zero
        if (sx == 0 && sy == 0)
            return res;
        x = sx * 1024;
        y = sy * 1024;
        z = 0;
        // fold the left half plane over
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_CIRCLE;
        end
        for (j = 0; j < 16; j++)
        begin
            xs = x >>> j;
            ys = y >>> j;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q14[j];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q14[j];
            end
        end
        while (z < 0)
            z += FULL_CIRCLE;
        while (z >= FULL_CIRCLE)
            z -= FULL_CIRCLE;
        angle = (z + 128) >>> 8;
        if (angle >= ANGLE_WRAP)
            angle -= ANGLE_WRAP;
        res.direction_angle = ANGLE_W'(angle);
        return res;
    endfunction

    task automatic send_snapshot(input logic [BITS_W-1:0] bits,
                                 input logic [CENTER_W-1:0] center);
        snapshot_t s;
        s.bits = bits;
        s.center = center;
        snapshot_queue.push_back(s);
    endtask

    // wait until every queued word went in and every result came back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (snapshot_queue.size() != 0 || sample_in.valid || direction_queue.size() != 0);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_register(input logic [PADDR_W-1:0] addr,
                                  input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WINDOW_RADIUS)
        begin
            scan_radius = data[RADIUS_W-1:0];
            radius_settings++;
        end
    endtask

    task automatic set_radius(input logic [RADIUS_W-1:0] radius);
        write_register(ADDR_WINDOW_RADIUS, ($urandom & 32'hFFFF_FFF0) | 32'(radius));
    endtask

    // input driver: one word at a time from the snapshot queue
    always @(posedge clk)
    begin
        result_t predicted;
        if (!rst_n)
        begin
            sample_in.valid <= 1'b0;
            sample_in.sensor_bits <= '0;
            sample_in.window_center <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (sample_in.valid && sample_in.ready)
            begin
                predicted = estimate_direction(sample_in.sensor_bits,
                                               sample_in.window_center, scan_radius);
                direction_queue.push_back(predicted);
                words_accepted++;
                if (!predicted.angle_valid)
                    empty_windows++;
                else if (predicted.direction_angle == '0)
                    zero_angles++;
            end
            if (sample_in.valid && !sample_in.ready)
            begin
                // hold the word until it is taken
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                sample_in.valid <= 1'b0;
            end
            else if (snapshot_queue.size() != 0)
            begin
                sample_in.sensor_bits <= snapshot_queue[0].bits;
                sample_in.window_center <= snapshot_queue[0].center;
                void'(snapshot_queue.pop_front());
                sample_in.valid <= 1'b1;
                gap_left <= in_idle_on ? int'($urandom_range(0, 10)) : 0;
            end
            else
                sample_in.valid <= 1'b0;
        end
    end

    // result checker and per-word output stall
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        int wait_cycles;
        if (!rst_n)
        begin
            out_ready_q <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (result_out.valid && result_out.ready)
            begin
                got.angle_valid = result_out.angle_valid;
                got.direction_angle = result_out.direction_angle;
                got.active_count = result_out.active_count;
                if (direction_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result word, expected none, actual %p",
                                 $time, got);
                end
                else
                begin
                    want = direction_queue.pop_front();
                    results_checked++;
                    if (got.angle_valid !== want.angle_valid)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: angle_valid expected %0d actual %0d",
                                     $time, want.angle_valid, got.angle_valid);
                    end
                    if (got.direction_angle !== want.direction_angle)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: direction_angle expected %0d actual %0d",
                                     $time, want.direction_angle, got.direction_angle);
                    end
                    if (got.active_count !== want.active_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: active_count expected %0d actual %0d",
                                     $time, want.active_count, got.active_count);
                    end
                end
                wait_cycles = out_idle_on ? int'($urandom_range(0, 10)) : 0;
            end
            else
                wait_cycles = (stall_left != 0) ? stall_left - 1 : 0;
            stall_left <= wait_cycles;
            out_ready_q <= (wait_cycles == 0);
        end
    end

    // long output hold-off, fired once when armed
    always @(posedge clk)
    begin
        if (!rst_n)
            choke_left <= 0;
        else if (choke_arm && !choke_used)
        begin
            choke_left <= CHOKE_CYCLES;
            choke_used <= 1'b1;
        end
        else if (choke_left != 0)
            choke_left <= choke_left - 1;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [BITS_W-1:0] bits;
        logic [RADIUS_W-1:0] radius;
        int kind;
        int start;
        int len;
        int k;
        int p;
        int n;
        sample_in.valid = 1'b0;
        sample_in.sensor_bits = '0;
        sample_in.window_center = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset radius 7: extremes, wrap, window edges, quadrant points
        send_snapshot(32'hFFFF_FFFF, 5'd0);
        send_snapshot(32'h0000_0000, 5'd0);
        send_snapshot(32'h0000_0000, 5'd31);
        send_snapshot(~(32'd1 << 0), 5'd0);
        send_snapshot(~(32'd1 << 31), 5'd0);
        send_snapshot(~(32'd1 << 8), 5'd0);
        send_snapshot(~(32'd1 << 7), 5'd0);
        send_snapshot(~(32'd1 << 16), 5'd16);
        send_snapshot(~(32'd1 << 24), 5'd24);
        send_snapshot(32'h5555_5555, 5'd10);
        wait_drained();

        // a write to an unknown register leaves the radius alone
        write_register(ADDR_UNUSED, 32'h0000_000F);
        send_snapshot(~(32'd1 << 8), 5'd0);
        wait_drained();

        // widest window: exact cancellation, full window, far side excluded
        set_radius(4'd15);
        send_snapshot(~((32'd1 << 3) | (32'd1 << 19)), 5'd11);
        send_snapshot(32'h0000_0000, 5'd5);
        send_snapshot(~(32'd1 << 20), 5'd4);
        send_snapshot(32'h0000_FFFF, 5'd0);
        wait_drained();

        // narrowest window: only the centre position
        set_radius(4'd0);
        send_snapshot(~(32'd1 << 9), 5'd9);
        send_snapshot(~(32'd1 << 9), 5'd10);
        send_snapshot(32'h0000_0000, 5'd31);
        wait_drained();

        // random phases over several radius settings
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       radius = 4'd15;
                1:       radius = 4'd0;
                2:       radius = 4'd7;
                3:       radius = 4'd1;
                4:       radius = 4'd14;
                default: radius = RADIUS_W'($urandom_range(0, 15));
            endcase
            set_radius(radius);
            in_idle_on = !(p == 1 || p == 3 || p == 5);
            out_idle_on = !(p == 2 || p == 5);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                kind = $urandom_range(0, 9);
                bits = '1;
                case (kind)
                    0, 1:
                        bits = $urandom;
                    2, 3:
                    begin
                        // a few scattered active sensors
                        repeat ($urandom_range(1, 3)) bits[$urandom_range(0, 31)] = 1'b0;
                    end
                    4, 5, 6:
                    begin
                        // a line seen as a run of neighboring sensors
                        start = $urandom_range(0, 31);
                        len = $urandom_range(1, 12);
                        for (k = 0; k < len; k++)
                            bits[(start + k) % SENSOR_COUNT] = 1'b0;
                    end
                    7:
                    begin
                        // opposite pair, often cancelling
                        start = $urandom_range(0, 31);
                        bits[start] = 1'b0;
                        bits[(start + 16) % SENSOR_COUNT] = 1'b0;
                        if ($urandom_range(0, 1) == 1)
                            bits[$urandom_range(0, 31)] = 1'b0;
                    end
                    8:
                        bits = $urandom & $urandom;
                    default:
                        bits = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                endcase
                send_snapshot(bits, CENTER_W'($urandom_range(0, 31)));
            end
            // hold the output off while the sender keeps going
            if (p == 3)
            begin
                @(negedge clk);
                choke_arm = 1'b1;
            end
            wait_drained();
        end

        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        wait_drained();
        repeat (PIPE_DEPTH) @(posedge clk);

        $display("checked %0d of %0d words over %0d radius settings, incl. 0 and 15",
                 results_checked, words_accepted, radius_settings);
        $display("%0d empty windows, %0d zero angles, one %0d cycle output hold-off",
                 empty_windows, zero_angles, CHOKE_CYCLES);
        if (mismatch_count == 0 && direction_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
design/sre_pkg.sv
design/sre_if.sv
design/sre_lane.sv
design/sre_merge.sv
design/sre_cordic.sv
design/sensor_ring_direction_estimator.sv
sim/sensor_ring_direction_estimator_test.sv
